### hw/rtl/cascaded_biquad_iir_filter_core_macros.svh
// assertion macros shared by the biquad filter core rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CASCADED_BIQUAD_IIR_FILTER_CORE_MACROS_SVH
`define CASCADED_BIQUAD_IIR_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CBIQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CBIQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/cbiq_pkg.sv
// shared constants, types, microcode rom and rounding functions of the biquad core
// no dependencies; used by every other rtl file of the block but cbiq_ram
`timescale 1ns / 1ps

package cbiq_pkg;

   // sizing
   localparam int SECTION_COUNT     = 4;
   localparam int SLOTS_PER_SECTION = 5;
   localparam int COEF_DEPTH        = SECTION_COUNT * SLOTS_PER_SECTION;
   localparam int COEF_ADDR_W       = $clog2(COEF_DEPTH);
   localparam int SEC_W             = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
   localparam int CNT_W             = $clog2(SECTION_COUNT + 1);

   // field widths
   localparam int ACTION_W  = 2;
   localparam int SAMPLE_W  = 16;
   localparam int SECTION_W = 2;
   localparam int SLOT_W    = 3;
   localparam int COEF_W    = 24;
   localparam int ACTIVE_W  = 3;

   // datapath widths: state q8.24, products q12.44, accumulator with headroom
   localparam int STATE_W    = 32;
   localparam int PROD_W     = COEF_W + STATE_W;
   localparam int ACC_W      = 58;
   localparam int FRAC_SHIFT = 20;
   localparam int IN_SHIFT   = 9;

   // transaction actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_FILTER = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   // coefficient slots inside a section
   localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

   typedef enum logic [1:0] {
      MUL_W1,
      MUL_W2,
      MUL_W
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NOP,
      ACC_LOAD_X,
      ACC_SUB,
      ACC_ADD,
      ACC_LOAD_P
   } acc_op_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_FILTER,
      OUT_BYPASS
   } out_op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_NO_SECTIONS,
      JMP_MORE
   } jmp_type;

   // program counter
   localparam int PROG_LEN = 10;
   localparam int PC_W     = $clog2(PROG_LEN);
   localparam logic [PC_W-1:0] PC_SECTION = 4'd0;
   localparam logic [PC_W-1:0] PC_BYPASS  = 4'd9;

   // datapath control word
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
      logic              mul_en;
      mul_sel_type       mul_sel;
      acc_op_type        acc_op;
      logic              w_load;
      logic              val_load;
      out_op_type        out_op;
   } ctrl_type;

   // full microinstruction
   typedef struct packed {
      ctrl_type        ctrl;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
      logic            last;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic no_sections;
      logic more_sections;
   } status_type;

   // finished result
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       saturated;
   } result_type;

   typedef struct packed {
      logic signed [STATE_W-1:0] value;
      logic                      clip;
   } round_state_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       clip;
   } round_sample_type;

   localparam ctrl_type CTRL_NOP = '{
      rd_en: 1'b0, rd_slot: SLOT_B0, mul_en: 1'b0, mul_sel: MUL_W1,
      acc_op: ACC_NOP, w_load: 1'b0, val_load: 1'b0, out_op: OUT_NONE};

   // microcode rom: one section takes steps 0..7, each coefficient read is registered before
   // its multiply, and each product is registered before it is accumulated
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type u;
      u        = '0;
      u.ctrl   = CTRL_NOP;
      u.jmp    = JMP_NONE;
      u.target = PC_SECTION;
      u.last   = 1'b0;
      case (pc)
         4'd0: begin
            u.ctrl.rd_en   = 1'b1;
            u.ctrl.rd_slot = SLOT_A1;
            u.ctrl.acc_op  = ACC_LOAD_X;
            u.jmp          = JMP_NO_SECTIONS;
            u.target       = PC_BYPASS;
         end
         4'd1: begin
            u.ctrl.rd_en   = 1'b1;
            u.ctrl.rd_slot = SLOT_A2;
            u.ctrl.mul_en  = 1'b1;
            u.ctrl.mul_sel = MUL_W1;
         end
         4'd2: begin
            u.ctrl.rd_en   = 1'b1;
            u.ctrl.rd_slot = SLOT_B1;
            u.ctrl.mul_en  = 1'b1;
            u.ctrl.mul_sel = MUL_W2;
            u.ctrl.acc_op  = ACC_SUB;
         end
         4'd3: begin
            u.ctrl.rd_en   = 1'b1;
            u.ctrl.rd_slot = SLOT_B2;
            u.ctrl.mul_en  = 1'b1;
            u.ctrl.mul_sel = MUL_W1;
            u.ctrl.acc_op  = ACC_SUB;
         end
         4'd4: begin
            u.ctrl.rd_en   = 1'b1;
            u.ctrl.rd_slot = SLOT_B0;
            u.ctrl.mul_en  = 1'b1;
            u.ctrl.mul_sel = MUL_W2;
            u.ctrl.w_load  = 1'b1;
            u.ctrl.acc_op  = ACC_LOAD_P;
         end
         4'd5: begin
            u.ctrl.mul_en  = 1'b1;
            u.ctrl.mul_sel = MUL_W;
            u.ctrl.acc_op  = ACC_ADD;
         end
         4'd6: begin
            u.ctrl.acc_op  = ACC_ADD;
         end
         4'd7: begin
            u.ctrl.val_load = 1'b1;
            u.jmp           = JMP_MORE;
            u.target        = PC_SECTION;
         end
         4'd8: begin
            u.ctrl.out_op = OUT_FILTER;
            u.last        = 1'b1;
         end
         4'd9: begin
            u.ctrl.out_op = OUT_BYPASS;
            u.last        = 1'b1;
         end
         default: begin
            u.last = 1'b1;
         end
      endcase
      return u;
   endfunction

   // q12.44 sum back to q8.24, round half up, saturate to 32 bits
   function automatic round_state_type round_state(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0]            biased;
      logic signed [ACC_W-FRAC_SHIFT-1:0] shifted;
      logic [ACC_W-FRAC_SHIFT-STATE_W:0]  top;
      round_state_type                    r;
      biased  = acc + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
      shifted = biased[ACC_W-1:FRAC_SHIFT];
      top     = shifted[ACC_W-FRAC_SHIFT-1:STATE_W-1];
      if ((&top) || !(|top)) begin
         r.value = shifted[STATE_W-1:0];
         r.clip  = 1'b0;
      end else begin
         r.value = shifted[ACC_W-FRAC_SHIFT-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                               : {1'b0, {(STATE_W-1){1'b1}}};
         r.clip  = 1'b1;
      end
      return r;
   endfunction

   // q8.24 value to q1.15, round half up, saturate to 16 bits
   function automatic round_sample_type round_sample(input logic signed [STATE_W-1:0] val);
      logic signed [STATE_W:0]          biased;
      logic signed [STATE_W-IN_SHIFT:0] shifted;
      logic [STATE_W-IN_SHIFT-SAMPLE_W+1:0] top;
      round_sample_type                 r;
      biased  = (STATE_W+1)'(val) + ((STATE_W+1)'(1) <<< (IN_SHIFT - 1));
      shifted = biased[STATE_W:IN_SHIFT];
      top     = shifted[STATE_W-IN_SHIFT:SAMPLE_W-1];
      if ((&top) || !(|top)) begin
         r.value = shifted[SAMPLE_W-1:0];
         r.clip  = 1'b0;
      end else begin
         r.value = shifted[STATE_W-IN_SHIFT] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                             : {1'b0, {(SAMPLE_W-1){1'b1}}};
         r.clip  = 1'b1;
      end
      return r;
   endfunction

endpackage

### hw/rtl/cbiq_if.sv
// handshake channel interfaces of the biquad core: request, response, register write
// depends on cbiq_pkg for field widths
`timescale 1ns / 1ps

// request channel: filter, coefficient load and clear transactions
interface cbiq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [cbiq_pkg::ACTION_W-1:0]         action;
   logic signed [cbiq_pkg::SAMPLE_W-1:0]  sample_in;
   logic [cbiq_pkg::SECTION_W-1:0]        section_index;
   logic [cbiq_pkg::SLOT_W-1:0]           coef_slot;
   logic signed [cbiq_pkg::COEF_W-1:0]    coef_value;

   modport source (output valid, action, sample_in, section_index, coef_slot, coef_value,
                   input ready);
   modport sink   (input valid, action, sample_in, section_index, coef_slot, coef_value,
                   output ready);
endinterface

// response channel: one filtered sample per filter transaction
interface cbiq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cbiq_pkg::SAMPLE_W-1:0]  sample_out;
   logic                                  saturated;

   modport source (output valid, sample_out, saturated, input ready);
   modport sink   (input valid, sample_out, saturated, output ready);
endinterface

// register write channel: active section count
interface cbiq_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cbiq_pkg::ACTIVE_W-1:0]   active_sections;

   modport source (output valid, active_sections, input ready);
   modport sink   (input valid, active_sections, output ready);
endinterface

### hw/rtl/cascaded_biquad_iir_filter_core.sv
// Load and clear transactions take effect at the accepting edge. A filter transaction runs the
// section steps once per active section and then the output step, or only the bypass step when
// no section is active; the next request is taken the cycle after the response is loaded.
// A new request is taken only when no filter transaction runs, and the output step waits for a
// free response register; all sections share one multiply-accumulate unit behind the registered
// coefficient ram read. Reset (synchronous) zeroes delay state, coefficients (per-entry valid
// bits), active_sections and the response valid flag.
// depends on cbiq_pkg, cbiq_if, cbiq_seq, cbiq_datapath and the macro header
`timescale 1ns / 1ps
`include "cascaded_biquad_iir_filter_core_macros.svh"

module cascaded_biquad_iir_filter_core (
   input  logic        clock,
   input  logic        reset,
   cbiq_req_if.sink    req_ch,
   cbiq_rsp_if.source  rsp_ch,
   cbiq_csr_if.sink    csr_ch
);

   logic [cbiq_pkg::ACTIVE_W-1:0]          active_ff, active_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [cbiq_pkg::SAMPLE_W-1:0]   rsp_sample_ff, rsp_sample_in;
   logic                                   rsp_sat_ff, rsp_sat_in;
   logic                                   req_fire;
   logic                                   start_en;
   logic                                   load_en;
   logic                                   clear_en;
   logic                                   out_free;
   logic                                   out_fire;
   logic                                   seq_idle;
   cbiq_pkg::ctrl_type                     seq_ctrl;
   cbiq_pkg::status_type                   dp_status;
   cbiq_pkg::result_type                   dp_result;

   // register write channel
   assign csr_ch.ready = 1'b1;
   always_comb begin
      active_in = active_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         active_in = csr_ch.active_sections;
      end
   end

   // request decode
   assign req_ch.ready = seq_idle;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign start_en     = req_fire && (req_ch.action == cbiq_pkg::ACT_FILTER);
   assign load_en      = req_fire && (req_ch.action == cbiq_pkg::ACT_LOAD);
   assign clear_en     = req_fire && (req_ch.action == cbiq_pkg::ACT_CLEAR);

   cbiq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start_en),
      .status   (dp_status),
      .out_free (out_free),
      .ctrl     (seq_ctrl),
      .idle     (seq_idle)
   );

   cbiq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (seq_ctrl),
      .start_en        (start_en),
      .load_en         (load_en),
      .clear_en        (clear_en),
      .sample_in       (req_ch.sample_in),
      .section_index   (req_ch.section_index),
      .coef_slot       (req_ch.coef_slot),
      .coef_value      (req_ch.coef_value),
      .active_sections (active_ff),
      .status          (dp_status),
      .result          (dp_result)
   );

   // response register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign out_fire = (seq_ctrl.out_op != cbiq_pkg::OUT_NONE) && out_free;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (out_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = dp_result.sample;
         rsp_sat_in    = dp_result.saturated;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_sample_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;

   // a filter transaction keeps the request side closed while it runs
   `CBIQ_ASSERT_NEXT(a_filter_blocks_req, clock, reset, start_en, !req_ch.ready,
      "request accepted while a filter transaction is running")

   // a finished sample always lands in the response register
   `CBIQ_ASSERT_NEXT(a_out_loads_rsp, clock, reset, out_fire, rsp_valid_ff,
      "finished sample did not reach the response register")

   // bypass never reports clipping
   `CBIQ_ASSERT_NEXT(a_bypass_no_sat, clock, reset,
      out_fire && (seq_ctrl.out_op == cbiq_pkg::OUT_BYPASS), !rsp_sat_ff,
      "bypass response flagged as saturated")

endmodule

### hw/rtl/cbiq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module cbiq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cbiq_seq.sv
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on cbiq_pkg for the rom, control word and status types
`timescale 1ns / 1ps

module cbiq_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cbiq_pkg::status_type status,
   input  logic                 out_free,
   output cbiq_pkg::ctrl_type   ctrl,
   output logic                 idle
);

   logic [cbiq_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                      busy_ff, busy_in;
   cbiq_pkg::ucode_type       uword;
   logic                      stall;
   logic                      taken;

   // fetch the current control word
   assign uword = cbiq_pkg::ucode_rom(pc_ff);

   // output steps wait for the response register to free up
   assign stall = busy_ff && (uword.ctrl.out_op != cbiq_pkg::OUT_NONE) && !out_free;

   // jump condition
   always_comb begin
      case (uword.jmp)
         cbiq_pkg::JMP_NO_SECTIONS: taken = status.no_sections;
         cbiq_pkg::JMP_MORE:        taken = status.more_sections;
         default:                   taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = cbiq_pkg::PC_SECTION;
         end
      end else if (!stall) begin
         if (uword.last) begin
            busy_in = 1'b0;
            pc_in   = cbiq_pkg::PC_SECTION;
         end else if (taken) begin
            pc_in = uword.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= cbiq_pkg::PC_SECTION;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   // control only acts while a filter transaction runs
   assign ctrl = busy_ff ? uword.ctrl : cbiq_pkg::CTRL_NOP;
   assign idle = !busy_ff;

endmodule

### hw/rtl/cbiq_datapath.sv
// biquad datapath: coefficient ram, delay state, shared multiply-accumulate, rounding
// depends on cbiq_pkg and cbiq_ram
`timescale 1ns / 1ps

module cbiq_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cbiq_pkg::ctrl_type                    ctrl,
   input  logic                                  start_en,
   input  logic                                  load_en,
   input  logic                                  clear_en,
   input  logic signed [cbiq_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic [cbiq_pkg::SECTION_W-1:0]        section_index,
   input  logic [cbiq_pkg::SLOT_W-1:0]           coef_slot,
   input  logic signed [cbiq_pkg::COEF_W-1:0]    coef_value,
   input  logic [cbiq_pkg::ACTIVE_W-1:0]         active_sections,
   output cbiq_pkg::status_type                  status,
   output cbiq_pkg::result_type                  result
);

   logic signed [cbiq_pkg::STATE_W-1:0] delay_one_ff [cbiq_pkg::SECTION_COUNT];
   logic signed [cbiq_pkg::STATE_W-1:0] delay_one_in [cbiq_pkg::SECTION_COUNT];
   logic signed [cbiq_pkg::STATE_W-1:0] delay_two_ff [cbiq_pkg::SECTION_COUNT];
   logic signed [cbiq_pkg::STATE_W-1:0] delay_two_in [cbiq_pkg::SECTION_COUNT];
   logic [cbiq_pkg::COEF_DEPTH-1:0]     coef_valid_ff, coef_valid_in;
   logic                                coef_rd_valid_ff, coef_rd_valid_in;
   logic [cbiq_pkg::SEC_W-1:0]          sec_ff, sec_in;
   logic                                clip_ff, clip_in;
   logic signed [cbiq_pkg::STATE_W-1:0] val_ff, val_in;
   logic signed [cbiq_pkg::STATE_W-1:0] w_ff, w_in;
   logic signed [cbiq_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [cbiq_pkg::PROD_W-1:0]  prod_ff, prod_in;

   logic [cbiq_pkg::CNT_W-1:0]          n_sections;
   logic                                load_ok;
   logic [cbiq_pkg::COEF_ADDR_W-1:0]    wr_addr;
   logic [cbiq_pkg::COEF_ADDR_W-1:0]    rd_addr;
   logic [cbiq_pkg::COEF_W-1:0]         ram_rdata;
   logic signed [cbiq_pkg::COEF_W-1:0]  coef_op;
   logic signed [cbiq_pkg::STATE_W-1:0] w1_cur, w2_cur;
   logic signed [cbiq_pkg::STATE_W-1:0] mul_op;
   cbiq_pkg::round_state_type           acc_round;
   cbiq_pkg::round_sample_type          out_round;

   // sections in use, clamped to the section count
   always_comb begin
      if (int'(active_sections) > cbiq_pkg::SECTION_COUNT) begin
         n_sections = cbiq_pkg::CNT_W'(cbiq_pkg::SECTION_COUNT);
      end else begin
         n_sections = cbiq_pkg::CNT_W'(active_sections);
      end
   end

   assign status.no_sections   = (n_sections == '0);
   assign status.more_sections = (cbiq_pkg::CNT_W'(sec_ff) + cbiq_pkg::CNT_W'(1)) < n_sections;

   // coefficient addressing: section * slots + slot
   assign load_ok = (int'(section_index) < cbiq_pkg::SECTION_COUNT)
                 && (int'(coef_slot) < cbiq_pkg::SLOTS_PER_SECTION);
   assign wr_addr = cbiq_pkg::COEF_ADDR_W'(section_index)
                  * cbiq_pkg::COEF_ADDR_W'(cbiq_pkg::SLOTS_PER_SECTION)
                  + cbiq_pkg::COEF_ADDR_W'(coef_slot);
   assign rd_addr = cbiq_pkg::COEF_ADDR_W'(sec_ff)
                  * cbiq_pkg::COEF_ADDR_W'(cbiq_pkg::SLOTS_PER_SECTION)
                  + cbiq_pkg::COEF_ADDR_W'(ctrl.rd_slot);

   cbiq_ram #(
      .WIDTH (cbiq_pkg::COEF_W),
      .DEPTH (cbiq_pkg::COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_en && load_ok),
      .wr_addr (wr_addr),
      .wr_data (coef_value),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // never-written coefficients read as zero
   always_comb begin
      coef_valid_in    = coef_valid_ff;
      coef_rd_valid_in = coef_rd_valid_ff;
      if (load_en && load_ok) begin
         coef_valid_in[wr_addr] = 1'b1;
      end
      if (ctrl.rd_en) begin
         coef_rd_valid_in = coef_valid_ff[rd_addr];
      end
   end

   assign coef_op = coef_rd_valid_ff ? $signed(ram_rdata) : '0;

   // current section delay pair
   assign w1_cur = delay_one_ff[sec_ff];
   assign w2_cur = delay_two_ff[sec_ff];

   // multiplier operand and product register
   always_comb begin
      case (ctrl.mul_sel)
         cbiq_pkg::MUL_W1: mul_op = w1_cur;
         cbiq_pkg::MUL_W2: mul_op = w2_cur;
         cbiq_pkg::MUL_W:  mul_op = w_ff;
         default:          mul_op = w1_cur;
      endcase
      prod_in = ctrl.mul_en ? (coef_op * mul_op) : prod_ff;
   end

   // accumulator
   always_comb begin
      case (ctrl.acc_op)
         cbiq_pkg::ACC_LOAD_X: acc_in = cbiq_pkg::ACC_W'(val_ff) <<< cbiq_pkg::FRAC_SHIFT;
         cbiq_pkg::ACC_SUB:    acc_in = acc_ff - cbiq_pkg::ACC_W'(prod_ff);
         cbiq_pkg::ACC_ADD:    acc_in = acc_ff + cbiq_pkg::ACC_W'(prod_ff);
         cbiq_pkg::ACC_LOAD_P: acc_in = cbiq_pkg::ACC_W'(prod_ff);
         default:              acc_in = acc_ff;
      endcase
   end

   assign acc_round = cbiq_pkg::round_state(acc_ff);
   assign out_round = cbiq_pkg::round_sample(val_ff);

   // section state, running value, clip flag
   always_comb begin
      delay_one_in = delay_one_ff;
      delay_two_in = delay_two_ff;
      sec_in       = sec_ff;
      clip_in      = clip_ff;
      val_in       = val_ff;
      w_in         = w_ff;
      if (start_en) begin
         val_in  = cbiq_pkg::STATE_W'(sample_in) <<< cbiq_pkg::IN_SHIFT;
         sec_in  = '0;
         clip_in = 1'b0;
      end
      if (ctrl.w_load) begin
         w_in    = acc_round.value;
         clip_in = clip_ff | acc_round.clip;
      end
      if (ctrl.val_load) begin
         val_in               = acc_round.value;
         clip_in              = clip_ff | acc_round.clip;
         delay_two_in[sec_ff] = w1_cur;
         delay_one_in[sec_ff] = w_ff;
         sec_in               = sec_ff + 1'b1;
      end
      if (clear_en) begin
         for (int i = 0; i < cbiq_pkg::SECTION_COUNT; i++) begin
            delay_one_in[i] = '0;
            delay_two_in[i] = '0;
         end
      end
   end

   // state with defined reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbiq_pkg::SECTION_COUNT; i++) begin
            delay_one_ff[i] <= '0;
            delay_two_ff[i] <= '0;
         end
         coef_valid_ff    <= '0;
         coef_rd_valid_ff <= 1'b0;
         sec_ff           <= '0;
         clip_ff          <= 1'b0;
      end else begin
         delay_one_ff     <= delay_one_in;
         delay_two_ff     <= delay_two_in;
         coef_valid_ff    <= coef_valid_in;
         coef_rd_valid_ff <= coef_rd_valid_in;
         sec_ff           <= sec_in;
         clip_ff          <= clip_in;
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      w_ff    <= w_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   // result: rounded output or the untouched sample in bypass
   always_comb begin
      if (ctrl.out_op == cbiq_pkg::OUT_BYPASS) begin
         result.sample    = val_ff[cbiq_pkg::SAMPLE_W+cbiq_pkg::IN_SHIFT-1:cbiq_pkg::IN_SHIFT];
         result.saturated = 1'b0;
      end else begin
         result.sample    = out_round.value;
         result.saturated = clip_ff | out_round.clip;
      end
   end

endmodule

### tb/cascaded_biquad_iir_filter_core_tb.sv
// self-checking testbench for the cascaded biquad filter core: directed table, then random phases
// depends on cbiq_pkg, cbiq_if and the core rtl; holds its own fixed-point model of the cascade
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter_core_tb;
   import cbiq_pkg::*;

   // action code the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sh100000;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7fffff;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
   localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

   localparam longint STATE_MAX  = (longint'(1) <<< (STATE_W - 1)) - 1;
   localparam longint STATE_MIN  = -(longint'(1) <<< (STATE_W - 1));
   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

   localparam int SETTLE_CYCLES = 8 * SECTION_COUNT + 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 300000;

   typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

   typedef struct packed {
      row_kind_t                  kind;
      logic [ACTION_W-1:0]        action;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SECTION_W-1:0]       section;
      logic [SLOT_W-1:0]          slot;
      logic signed [COEF_W-1:0]   coef;
      logic [ACTIVE_W-1:0]        active;
      logic                       fixed_exp;
      logic signed [SAMPLE_W-1:0] want_sample;
      logic                       want_sat;
   } plan_row_t;

   typedef struct packed {
      logic [ACTIVE_W-1:0] active;
      logic [6:0]          idle_pct;
      logic [6:0]          stall_pct;
      logic                hold;
   } phase_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbiq_req_if req_ch ();
   cbiq_rsp_if rsp_ch ();
   cbiq_csr_if csr_ch ();

   cascaded_biquad_iir_filter_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // model state
   logic signed [COEF_W-1:0]  coef_mem [COEF_DEPTH];
   logic signed [STATE_W-1:0] dly1 [SECTION_COUNT];
   logic signed [STATE_W-1:0] dly2 [SECTION_COUNT];
   logic [ACTIVE_W-1:0]       active_cfg;

   result_type pending_outputs [$];
   result_type head_output;
   plan_row_t  directed_plan [$];
   phase_t     phases [$];

   int cycle_count     = 0;
   int fail_count      = 0;
   int outputs_checked = 0;
   int loads_done      = 0;
   int clears_done     = 0;
   int ignored_done    = 0;
   int config_writes   = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_left       = 0;
   logic hold_go       = 1'b0;
   logic hold_used     = 1'b0;

   always #1 clock = ~clock;

   // round half up by a right shift, then clip to [lo, hi]
   function automatic longint round_sat(input longint v, input int sh, input longint lo,
                                        input longint hi, inout bit clip);
      longint r;
      r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r > hi) begin
         r    = hi;
         clip = 1'b1;
      end else if (r < lo) begin
         r    = lo;
         clip = 1'b1;
      end
      return r;
   endfunction

   // one sample through the active sections, updating the delay pairs
   function automatic result_type run_biquad_cascade(input logic signed [SAMPLE_W-1:0] x);
      longint     val, acc, w, w1, w2, b0, b1, b2, a1, a2;
      int         n, base;
      bit         clip;
      result_type r;
      clip = 1'b0;
      n    = (active_cfg > SECTION_COUNT) ? SECTION_COUNT : int'(active_cfg);
      if (n == 0) begin
         r.sample    = x;
         r.saturated = 1'b0;
      end else begin
         val = longint'(x) <<< IN_SHIFT;
         for (int i = 0; i < n; i++) begin
            base = i * SLOTS_PER_SECTION;
            b0   = longint'(coef_mem[base + SLOT_B0]);
            b1   = longint'(coef_mem[base + SLOT_B1]);
            b2   = longint'(coef_mem[base + SLOT_B2]);
            a1   = longint'(coef_mem[base + SLOT_A1]);
            a2   = longint'(coef_mem[base + SLOT_A2]);
            w1   = longint'(dly1[i]);
            w2   = longint'(dly2[i]);
            acc  = (val <<< FRAC_SHIFT) - a1 * w1 - a2 * w2;
            w    = round_sat(acc, FRAC_SHIFT, STATE_MIN, STATE_MAX, clip);
            acc  = b0 * w + b1 * w1 + b2 * w2;
            val  = round_sat(acc, FRAC_SHIFT, STATE_MIN, STATE_MAX, clip);
            dly2[i] = w1[STATE_W-1:0];
            dly1[i] = w[STATE_W-1:0];
         end
         val         = round_sat(val, IN_SHIFT, SAMPLE_MIN, SAMPLE_MAX, clip);
         r.sample    = val[SAMPLE_W-1:0];
         r.saturated = clip;
      end
      return r;
   endfunction

   function automatic plan_row_t plan_item(input logic [ACTION_W-1:0] act,
                                           input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [SECTION_W-1:0] sec,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic signed [COEF_W-1:0] cv,
                                           input logic fixed_exp,
                                           input logic signed [SAMPLE_W-1:0] want_smp,
                                           input logic want_sat);
      plan_row_t p;
      p             = '0;
      p.kind        = ROW_ITEM;
      p.action      = act;
      p.sample      = smp;
      p.section     = sec;
      p.slot        = slot;
      p.coef        = cv;
      p.fixed_exp   = fixed_exp;
      p.want_sample = want_smp;
      p.want_sat    = want_sat;
      return p;
   endfunction

   function automatic plan_row_t plan_config(input logic [ACTIVE_W-1:0] v);
      plan_row_t p;
      p        = '0;
      p.kind   = ROW_CONFIG;
      p.action = ACT_UNUSED;
      p.active = v;
      return p;
   endfunction

   function automatic phase_t plan_phase(input logic [ACTIVE_W-1:0] v, input int idle,
                                         input int stall, input logic hold);
      phase_t p;
      p.active    = v;
      p.idle_pct  = 7'(idle);
      p.stall_pct = 7'(stall);
      p.hold      = hold;
      return p;
   endfunction

   // append a row to the directed table
   task automatic add_row(input plan_row_t p);
      directed_plan.insert(directed_plan.size(), p);
   endtask

   // append a random phase
   task automatic add_phase(input phase_t p);
      phases.insert(phases.size(), p);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
               cycle_count, what, got, want);
   endtask

   // offer one transaction, wait for it to be taken, then update the model
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic signed [SAMPLE_W-1:0] smp,
                               input logic [SECTION_W-1:0] sec,
                               input logic [SLOT_W-1:0] slot,
                               input logic signed [COEF_W-1:0] cv,
                               input logic fixed_exp,
                               input logic signed [SAMPLE_W-1:0] want_smp,
                               input logic want_sat);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.sample_in     <= smp;
      req_ch.section_index <= sec;
      req_ch.coef_slot     <= slot;
      req_ch.coef_value    <= cv;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      case (act)
         ACT_LOAD: begin
            if (slot < SLOTS_PER_SECTION && sec < SECTION_COUNT)
               coef_mem[sec * SLOTS_PER_SECTION + slot] = cv;
            loads_done++;
         end
         ACT_CLEAR: begin
            foreach (dly1[i]) begin
               dly1[i] = '0;
               dly2[i] = '0;
            end
            clears_done++;
         end
         ACT_FILTER: begin
            r = run_biquad_cascade(smp);
            if (fixed_exp) begin
               r.sample    = want_smp;
               r.saturated = want_sat;
            end
            pending_outputs.insert(pending_outputs.size(), r);
         end
         default: begin
            ignored_done++;
         end
      endcase
   endtask

   // section count is written only once the block has drained
   task automatic write_active_sections(input logic [ACTIVE_W-1:0] v);
      req_ch.valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.active_sections <= v;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      active_cfg = v;
      config_writes++;
   endtask

   function automatic logic signed [COEF_W-1:0] rand_coef(input int span);
      return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // a full coefficient set of moderate values for every section
   task automatic load_coefficient_set();
      logic signed [COEF_W-1:0] cv;
      for (int s = 0; s < SECTION_COUNT; s++) begin
         for (int k = 0; k < SLOTS_PER_SECTION; k++) begin
            if (k == SLOT_A1)
               cv = rand_coef(1 << 21);
            else if (k == SLOT_A2)
               cv = rand_coef(1 << 20);
            else
               cv = rand_coef(1 << 19);
            send_request(ACT_LOAD, 16'($urandom()), SECTION_W'(s), SLOT_W'(k), cv,
                         1'b0, '0, 1'b0);
         end
      end
   endtask

   // mostly samples, with stray loads, clears and unused actions mixed in
   task automatic send_random_item();
      int                         pick;
      logic [ACTION_W-1:0]        act;
      logic signed [SAMPLE_W-1:0] smp;
      logic signed [COEF_W-1:0]   cv;
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0)
         smp = $urandom_range(1) ? SMP_MAX : SMP_MIN;
      else
         smp = 16'($urandom());
      cv = ($urandom_range(1) == 0) ? rand_coef(1 << 20) : 24'($urandom());
      if (pick < 75)
         act = ACT_FILTER;
      else if (pick < 86)
         act = ACT_LOAD;
      else if (pick < 93)
         act = ACT_CLEAR;
      else
         act = ACT_UNUSED;
      send_request(act, smp, SECTION_W'($urandom_range(3)), SLOT_W'($urandom_range(7)), cv,
                   1'b0, '0, 1'b0);
   endtask

   // response side: random stalls, plus one long hold-off when requested
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
   end

   // long hold-off counter
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // compare each response transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch("response with none outstanding", int'(rsp_ch.sample_out), 0);
         end else begin
            head_output = pending_outputs.pop_front();
            outputs_checked++;
            if (rsp_ch.sample_out !== head_output.sample)
               report_mismatch("sample_out", int'(rsp_ch.sample_out),
                               int'(head_output.sample));
            if (rsp_ch.saturated !== head_output.saturated)
               report_mismatch("saturated", int'(rsp_ch.saturated),
                               int'(head_output.saturated));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_outputs.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // stimulus
   initial begin
      req_ch.valid           = 1'b0;
      req_ch.action          = ACT_FILTER;
      req_ch.sample_in       = '0;
      req_ch.section_index   = '0;
      req_ch.coef_slot       = SLOT_B0;
      req_ch.coef_value      = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.active_sections = '0;
      active_cfg             = '0;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (dly1[i]) begin
         dly1[i] = '0;
         dly2[i] = '0;
      end

      // directed rows: bypass after reset, bad slots, full-scale gain, state blow-up,
      // clear, section count above range, bypass keeping state, inactive sections
      add_row(plan_item(ACT_FILTER, SMP_MAX, 0, SLOT_B0, 0, 1, SMP_MAX, 0));
      add_row(plan_item(ACT_FILTER, SMP_MIN, 0, SLOT_B0, 0, 1, SMP_MIN, 0));
      add_row(plan_item(ACT_UNUSED, 16'sh1234, 3, 3'd7, COEF_MIN, 0, 0, 0));
      add_row(plan_item(ACT_LOAD, 0, 0, SLOT_B0, COEF_ONE, 0, 0, 0));
      add_row(plan_item(ACT_LOAD, 0, 0, 3'd5, COEF_MAX, 0, 0, 0));
      add_row(plan_item(ACT_LOAD, 0, 0, 3'd7, COEF_MIN, 0, 0, 0));
      add_row(plan_config(3'd1));
      add_row(plan_item(ACT_FILTER, 16'sd12345, 0, SLOT_B0, 0, 1, 16'sd12345, 0));
      add_row(plan_item(ACT_LOAD, 0, 0, SLOT_B0, COEF_MAX, 0, 0, 0));
      add_row(plan_item(ACT_FILTER, SMP_MAX, 0, SLOT_B0, 0, 1, SMP_MAX, 1));
      add_row(plan_item(ACT_FILTER, SMP_MIN, 0, SLOT_B0, 0, 1, SMP_MIN, 1));
      add_row(plan_item(ACT_LOAD, 0, 0, SLOT_A1, COEF_MIN, 0, 0, 0));
      add_row(plan_item(ACT_FILTER, 16'sd20000, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_item(ACT_FILTER, 16'sd20000, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_item(ACT_FILTER, SMP_MAX, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_item(ACT_CLEAR, 0, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_item(ACT_FILTER, 0, 0, SLOT_B0, 0, 1, 0, 0));
      add_row(plan_item(ACT_LOAD, 0, 1, SLOT_B1, COEF_ONE, 0, 0, 0));
      add_row(plan_item(ACT_LOAD, 0, 2, SLOT_B0, COEF_ONE, 0, 0, 0));
      add_row(plan_item(ACT_LOAD, 0, 3, SLOT_B2, COEF_MIN, 0, 0, 0));
      add_row(plan_config(3'd7));
      add_row(plan_item(ACT_FILTER, -16'sd12345, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_item(ACT_FILTER, SMP_MAX, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_config(3'd0));
      add_row(plan_item(ACT_FILTER, -16'sd1, 0, SLOT_B0, 0, 1, -16'sd1, 0));
      add_row(plan_config(3'd4));
      add_row(plan_item(ACT_FILTER, 16'sd100, 0, SLOT_B0, 0, 0, 0, 0));
      add_row(plan_config(3'd2));
      add_row(plan_item(ACT_FILTER, 16'sd3000, 0, SLOT_B0, 0, 0, 0, 0));

      // random phases: section count, sender idle percent, receiver stall percent, hold-off
      add_phase(plan_phase(3'd1, 0, 0, 1'b0));
      add_phase(plan_phase(3'd4, 80, 0, 1'b0));
      add_phase(plan_phase(3'd2, 0, 80, 1'b0));
      add_phase(plan_phase(3'd3, 22, 22, 1'b0));
      add_phase(plan_phase(3'd7, 0, 0, 1'b1));
      add_phase(plan_phase(3'd0, 22, 22, 1'b0));
      add_phase(plan_phase(3'd5, 80, 0, 1'b0));
      add_phase(plan_phase(3'd6, 0, 80, 1'b0));
      add_phase(plan_phase(3'd4, 0, 0, 1'b0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CONFIG)
            write_active_sections(directed_plan[i].active);
         else
            send_request(directed_plan[i].action, directed_plan[i].sample,
                         directed_plan[i].section, directed_plan[i].slot,
                         directed_plan[i].coef, directed_plan[i].fixed_exp,
                         directed_plan[i].want_sample, directed_plan[i].want_sat);
      end

      // random part: each phase loads a fresh coefficient set, clears, then streams
      foreach (phases[p]) begin
         write_active_sections(phases[p].active);
         send_idle_pct = phases[p].idle_pct;
         stall_pct    <= int'(phases[p].stall_pct);
         if (phases[p].hold)
            hold_go <= 1'b1;
         load_coefficient_set();
         send_request(ACT_CLEAR, '0, '0, SLOT_B0, '0, 1'b0, '0, 1'b0);
         repeat (34) send_random_item();
      end

      // drain
      req_ch.valid <= 1'b0;
      stall_pct    <= 0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d filtered samples; %0d coefficient loads, %0d clears,",
               outputs_checked, loads_done, clears_done);
      $display("%0d unused-action transactions and %0d section count writes (0 through 7)",
               ignored_done, config_writes);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cbiq_pkg.sv
hw/rtl/cbiq_if.sv
hw/rtl/cbiq_ram.sv
hw/rtl/cbiq_seq.sv
hw/rtl/cbiq_datapath.sv
hw/rtl/cascaded_biquad_iir_filter_core.sv
tb/cascaded_biquad_iir_filter_core_tb.sv
